// File: hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: quadratic root solver shared types
// Payload structs, widths of the datapath and root class codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_W = 32;
	localparam int FRAC_W = 16;
	localparam int TOL_W  = 16;
	localparam int ROOT_W = COEF_W + 1;      // sqrt result, one cell per bit
	localparam int DISC_W = 2 * ROOT_W;      // discriminant magnitude
	localparam int NUM_W  = COEF_W + 3;      // numerator magnitude
	localparam int DVS_W  = COEF_W + 1;      // divisor magnitude (2a, or b for the linear case)
	localparam int QUO_W  = NUM_W + FRAC_W;  // quotient bits, one cell per bit

	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_ONE  = 2'd1;
	localparam logic [1:0] CLS_TWO  = 2'd2;
	localparam logic [1:0] CLS_INF  = 2'd3;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
	} coef_t;

	typedef struct packed {
		logic [1:0]               root_class;
		logic signed [COEF_W-1:0] root_first;
		logic signed [COEF_W-1:0] root_second;
		logic                     saturated;
	} result_t;

	// carried beside the square root chain
	typedef struct packed {
		logic [1:0]           cls;
		logic signed [COEF_W:0] nbase;   // -b, or -c for the linear case
		logic                 den_neg;
		logic [DVS_W-1:0]     den_mag;
	} sq_pay_t;

	// carried beside the divider chains
	typedef struct packed {
		logic [1:0] cls;
		logic       neg1;
		logic       neg2;
	} dv_pay_t;

endpackage

// File: hw/rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver: roots of a*x^2 + b*x + c = 0 in signed Q16.16
// Pipelined through the front stages, the square root cell chain and the divider
// cell chains, with widths set for Q16.16; one item per cycle.
// busy stays low, results are never held back by the receiver.
// Reset clears all valid flags and loads zero_tolerance with 1.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  qrs_pkg::coef_t          coef,
	output logic                    done,
	output qrs_pkg::result_t        result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [qrs_pkg::TOL_W-1:0] cfg_data
);
	import qrs_pkg::*;

	logic             acc;
	logic [TOL_W-1:0] tol_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// stage 1: magnitudes and zero tests
	logic              vld_s1;
	logic [COEF_W-1:0] am_s1, bm_s1, cm_s1;
	logic              an_s1, bn_s1, cn_s1, abig_s1, bbig_s1, cbig_s1;
	logic [COEF_W-1:0] am_c, bm_c, cm_c;

	always_comb begin
		am_c = coef.coef_a[COEF_W-1] ? COEF_W'(-coef.coef_a) : coef.coef_a;
		bm_c = coef.coef_b[COEF_W-1] ? COEF_W'(-coef.coef_b) : coef.coef_b;
		cm_c = coef.coef_c[COEF_W-1] ? COEF_W'(-coef.coef_c) : coef.coef_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		am_s1   <= am_c;
		bm_s1   <= bm_c;
		cm_s1   <= cm_c;
		an_s1   <= coef.coef_a[COEF_W-1];
		bn_s1   <= coef.coef_b[COEF_W-1];
		cn_s1   <= coef.coef_c[COEF_W-1];
		abig_s1 <= am_c > COEF_W'(tol_q);
		bbig_s1 <= bm_c > COEF_W'(tol_q);
		cbig_s1 <= cm_c > COEF_W'(tol_q);
	end

	// stage 2: products
	logic                vld_s2;
	logic [2*COEF_W-1:0] b2_s2, ac_s2;
	logic [COEF_W-1:0]   am_s2, bm_s2, cm_s2;
	logic                an_s2, bn_s2, cn_s2, abig_s2, bbig_s2, cbig_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		b2_s2   <= bm_s1 * bm_s1;
		ac_s2   <= am_s1 * cm_s1;
		am_s2   <= am_s1;
		bm_s2   <= bm_s1;
		cm_s2   <= cm_s1;
		an_s2   <= an_s1;
		bn_s2   <= bn_s1;
		cn_s2   <= cn_s1;
		abig_s2 <= abig_s1;
		bbig_s2 <= bbig_s1;
		cbig_s2 <= cbig_s1;
	end

	// stage 3: discriminant and class
	logic [DISC_W-1:0] b2e, ac4, tolw, dmag_c;
	logic              dneg_c;
	sq_pay_t           pay_c;

	always_comb begin
		b2e    = DISC_W'(b2_s2);
		ac4    = {ac_s2, 2'b00};
		tolw   = DISC_W'({tol_q, {FRAC_W{1'b0}}});
		dneg_c = 1'b0;
		if (an_s2 != cn_s2) begin
			dmag_c = b2e + ac4;
		end else if (b2e >= ac4) begin
			dmag_c = b2e - ac4;
		end else begin
			dmag_c = ac4 - b2e;
			dneg_c = 1'b1;
		end
		pay_c.nbase   = bn_s2 ? $signed({1'b0, bm_s2}) : -$signed({1'b0, bm_s2});
		pay_c.den_neg = an_s2;
		pay_c.den_mag = {am_s2, 1'b0};
		if (abig_s2) begin
			if (!dneg_c && dmag_c > tolw) pay_c.cls = CLS_TWO;
			else if (dmag_c <= tolw)      pay_c.cls = CLS_ONE;
			else                          pay_c.cls = CLS_NONE;
		end else if (!bbig_s2) begin
			pay_c.cls = cbig_s2 ? CLS_NONE : CLS_INF;
		end else begin
			// linear: -c / b
			pay_c.cls     = CLS_ONE;
			pay_c.nbase   = cn_s2 ? $signed({1'b0, cm_s2}) : -$signed({1'b0, cm_s2});
			pay_c.den_neg = bn_s2;
			pay_c.den_mag = DVS_W'(bm_s2);
		end
	end

	logic              vld_s3;
	logic [DISC_W-1:0] dmag_s3;
	sq_pay_t           pay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		dmag_s3 <= dmag_c;
		pay_s3  <= pay_c;
	end

	// square root chain
	logic [ROOT_W+1:0] sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root [ROOT_W+1];
	logic [DISC_W-1:0] sq_rad  [ROOT_W+1];
	logic              sq_vld  [ROOT_W+1];
	sq_pay_t           sq_pay  [ROOT_W+1];

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = dmag_s3;
	assign sq_vld[0]  = vld_s3;
	assign sq_pay[0]  = pay_s3;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
		logic    vld_q;
		sq_pay_t pay_q;

		qrs_sqrt_cell u_cell (
			.clk    (clk),
			.rem    (sq_rem[k]),
			.root   (sq_root[k]),
			.rad    (sq_rad[k]),
			.rem_q  (sq_rem[k+1]),
			.root_q (sq_root[k+1]),
			.rad_q  (sq_rad[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q <= 1'b0;
			else         vld_q <= sq_vld[k];
		end

		always_ff @(posedge clk) begin
			pay_q <= sq_pay[k];
		end

		assign sq_vld[k+1] = vld_q;
		assign sq_pay[k+1] = pay_q;
	end

	// stage 4: numerators
	sq_pay_t           sp;
	logic signed [NUM_W:0] sroot, nb, n1, n2;

	always_comb begin
		sp    = sq_pay[ROOT_W];
		sroot = $signed({{(NUM_W+1-ROOT_W){1'b0}}, sq_root[ROOT_W]});
		nb    = (NUM_W+1)'(sp.nbase);
		n1    = '0;
		n2    = '0;
		if (sp.cls == CLS_TWO) begin
			n1 = nb - sroot;
			n2 = nb + sroot;
		end else if (sp.cls == CLS_ONE) begin
			n1 = nb;
		end
	end

	logic              vld_s4;
	logic [NUM_W-1:0]  m1_s4, m2_s4;
	logic [DVS_W-1:0]  den_s4;
	dv_pay_t           dpay_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= sq_vld[ROOT_W];
	end

	always_ff @(posedge clk) begin
		m1_s4        <= n1[NUM_W] ? NUM_W'(-n1) : n1[NUM_W-1:0];
		m2_s4        <= n2[NUM_W] ? NUM_W'(-n2) : n2[NUM_W-1:0];
		den_s4       <= sp.den_mag;
		dpay_s4.cls  <= sp.cls;
		dpay_s4.neg1 <= n1[NUM_W] != sp.den_neg;
		dpay_s4.neg2 <= n2[NUM_W] != sp.den_neg;
	end

	// divider chains, one lane per root
	logic [DVS_W-1:0] dv_rem [2][QUO_W+1];
	logic [QUO_W-1:0] dv_dvd [2][QUO_W+1];
	logic [QUO_W-1:0] dv_quo [2][QUO_W+1];
	logic [DVS_W-1:0] dv_dvs [2][QUO_W+1];
	logic             dv_vld [QUO_W+1];
	dv_pay_t          dv_pay [QUO_W+1];

	assign dv_dvd[0][0] = {m1_s4, {FRAC_W{1'b0}}};
	assign dv_dvd[1][0] = {m2_s4, {FRAC_W{1'b0}}};
	assign dv_vld[0]    = vld_s4;
	assign dv_pay[0]    = dpay_s4;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign dv_rem[l][0] = '0;
		assign dv_quo[l][0] = '0;
		assign dv_dvs[l][0] = den_s4;
		for (genvar k = 0; k < QUO_W; k++) begin : g_dv
			qrs_div_cell u_cell (
				.clk   (clk),
				.rem   (dv_rem[l][k]),
				.dvd   (dv_dvd[l][k]),
				.quo   (dv_quo[l][k]),
				.dvs   (dv_dvs[l][k]),
				.rem_q (dv_rem[l][k+1]),
				.dvd_q (dv_dvd[l][k+1]),
				.quo_q (dv_quo[l][k+1]),
				.dvs_q (dv_dvs[l][k+1])
			);
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_dvp
		logic    vld_q;
		dv_pay_t pay_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q <= 1'b0;
			else         vld_q <= dv_vld[k];
		end

		always_ff @(posedge clk) begin
			pay_q <= dv_pay[k];
		end

		assign dv_vld[k+1] = vld_q;
		assign dv_pay[k+1] = pay_q;
	end

	// output stage: clamp, sign, mask unused slots
	dv_pay_t           fp;
	logic [QUO_W-1:0]  lim1, lim2, q1, q2;
	logic              sat1, sat2, use1, use2;
	logic [COEF_W-1:0] r1, r2;
	result_t           res_c;

	always_comb begin
		fp   = dv_pay[QUO_W];
		q1   = dv_quo[0][QUO_W];
		q2   = dv_quo[1][QUO_W];
		lim1 = QUO_W'({1'b0, fp.neg1, {(COEF_W-1){!fp.neg1}}});
		lim2 = QUO_W'({1'b0, fp.neg2, {(COEF_W-1){!fp.neg2}}});
		use1 = (fp.cls == CLS_ONE) || (fp.cls == CLS_TWO);
		use2 = (fp.cls == CLS_TWO);
		sat1 = use1 && (q1 > lim1);
		sat2 = use2 && (q2 > lim2);
		r1   = sat1 ? lim1[COEF_W-1:0] : q1[COEF_W-1:0];
		r2   = sat2 ? lim2[COEF_W-1:0] : q2[COEF_W-1:0];
		if (fp.neg1) r1 = COEF_W'(-r1);
		if (fp.neg2) r2 = COEF_W'(-r2);
		res_c.root_class  = fp.cls;
		res_c.root_first  = use1 ? r1 : '0;
		res_c.root_second = use2 ? r2 : '0;
		res_c.saturated   = sat1 || sat2;
	end

	logic    done_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= dv_vld[QUO_W];
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
	end

	assign done   = done_q;
	assign result = res_q;

	a_second_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.root_class != CLS_TWO |-> result.root_second == '0)
		else $error("second root set without two roots");

	a_first_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.root_class == CLS_NONE || result.root_class == CLS_INF)
		|-> result.root_first == '0 && !result.saturated)
		else $error("root or saturation reported without a root");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ##2 vld_s3)
		else $error("accepted item lost before square root chain");

	a_chain_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld[0] |-> $past(sq_vld[ROOT_W]))
		else $error("divider entry without square root exit");

endmodule

// File: hw/rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the square root chain
// Brings down two radicand bits, decides one root bit, registers the result.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
	input  logic                                  clk,
	input  logic [qrs_pkg::ROOT_W+1:0]            rem,
	input  logic [qrs_pkg::ROOT_W-1:0]            root,
	input  logic [qrs_pkg::DISC_W-1:0]            rad,
	output logic [qrs_pkg::ROOT_W+1:0]            rem_q,
	output logic [qrs_pkg::ROOT_W-1:0]            root_q,
	output logic [qrs_pkg::DISC_W-1:0]            rad_q
);
	import qrs_pkg::*;

	localparam int RW = ROOT_W + 2;

	logic [RW+1:0] pre;
	logic [RW+1:0] trial;
	logic          take;

	always_comb begin
		pre   = {rem, rad[DISC_W-1 -: 2]};
		trial = {2'b00, root, 2'b01};
		take  = (pre >= trial);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q  <= RW'(pre - trial);
			root_q <= {root[ROOT_W-2:0], 1'b1};
		end else begin
			rem_q  <= pre[RW-1:0];
			root_q <= {root[ROOT_W-2:0], 1'b0};
		end
		rad_q <= {rad[DISC_W-3:0], 2'b00};
	end

endmodule

// File: hw/rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one step of the restoring divider chain
// Shifts in one dividend bit, subtracts the divisor if it fits, emits a bit.
// ----------------------------------------------------------------------------
module qrs_div_cell (
	input  logic                         clk,
	input  logic [qrs_pkg::DVS_W-1:0]    rem,
	input  logic [qrs_pkg::QUO_W-1:0]    dvd,
	input  logic [qrs_pkg::QUO_W-1:0]    quo,
	input  logic [qrs_pkg::DVS_W-1:0]    dvs,
	output logic [qrs_pkg::DVS_W-1:0]    rem_q,
	output logic [qrs_pkg::QUO_W-1:0]    dvd_q,
	output logic [qrs_pkg::QUO_W-1:0]    quo_q,
	output logic [qrs_pkg::DVS_W-1:0]    dvs_q
);
	import qrs_pkg::*;

	logic [DVS_W:0] pre;
	logic           take;

	always_comb begin
		pre  = {rem, dvd[QUO_W-1]};
		take = (pre >= {1'b0, dvs});
	end

	always_ff @(posedge clk) begin
		rem_q <= take ? DVS_W'(pre - {1'b0, dvs}) : pre[DVS_W-1:0];
		quo_q <= {quo[QUO_W-2:0], take};
		dvd_q <= {dvd[QUO_W-2:0], 1'b0};
		dvs_q <= dvs;
	end

endmodule
